// File: hw/rtl/esuc_pkg.sv
package esuc_pkg;

  typedef logic signed [63:0] epoch_t;
  typedef logic [5:0]         sixty_t;
  typedef logic [4:0]         hour_t;
  typedef logic [4:0]         mday_t;
  typedef logic [3:0]         month_t;
  typedef logic [13:0]        year_t;
  typedef logic [2:0]         wday_t;

  // First second past 9999-12-31 23:59:59, and the last one kept.
  localparam logic [62:0] TIME_LIMIT = 63'd253402300800;
  localparam logic [37:0] TIME_LAST  = 38'd253402300799;

  // 86400 = 128 * 675; days = (t >> 7) / 675
  localparam logic [9:0]  DAY_SLICE   = 10'd675;
  localparam logic [31:0] RECIP_675   = 32'd3257812231;   // ceil(2^41 / 675)

  // Day count since March 1 of year 0
  localparam logic [21:0] MARCH_OFFSET = 22'd719468;
  localparam logic [8:0]  YEAR_SCALE   = 9'd400;
  localparam logic [30:0] RECIP_146097 = 31'd1926630778;  // ceil(2^48 / 146097)

  localparam logic [13:0] RECIP_3600  = 14'd9321;         // (x >> 4) / 225, 2^21
  localparam logic [11:0] RECIP_100   = 12'd2622;         // (y >> 2) / 25, 2^16
  localparam logic [10:0] RECIP_60    = 11'd1093;         // (x >> 2) / 15, 2^14
  localparam logic [13:0] RECIP_MONTH = 14'd8570;         // 5 * 1714, 2^18

  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]  YEARS_PER_CENTURY = 7'd100;
  localparam logic [9:0]  MONTH_BIAS    = 10'd31;
  localparam logic [8:0]  JAN_DAY_INDEX = 9'd306;         // day index of Jan 1 in a March year
  localparam logic [3:0]  MONTH_WRAP    = 4'd10;
  localparam logic [3:0]  MONTH_SHIFT   = 4'd2;
  localparam logic [22:0] EPOCH_WDAY    = 23'd4;          // 1970-01-01 was a Thursday

  // (v mod 7) using 8 = 1 mod 7: add octal digits, then fold.
  function automatic wday_t mod7(input logic [22:0] v);
    logic [23:0] ext;
    logic [5:0]  sum;
    logic [3:0]  fold;
    ext = {1'b0, v};
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 6'(ext[3*i +: 3]);
    end
    fold = 4'(sum[5:3]) + 4'(sum[2:0]);
    if (fold >= 4'd7) begin
      fold = fold - 4'd7;
    end
    if (fold >= 4'd7) begin
      fold = fold - 4'd7;
    end
    return fold[2:0];
  endfunction

  // 367 * mon / 12 - 30: first day index of each March-based month
  function automatic logic [8:0] month_start(input month_t mon);
    logic [8:0] s;
    unique case (mon)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd61;
      4'd4:    s = 9'd92;
      4'd5:    s = 9'd122;
      4'd6:    s = 9'd153;
      4'd7:    s = 9'd184;
      4'd8:    s = 9'd214;
      4'd9:    s = 9'd245;
      4'd10:   s = 9'd275;
      4'd11:   s = 9'd306;
      4'd12:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/esuc_stamp_if.sv
interface esuc_stamp_if;
  import esuc_pkg::*;

  logic   valid;
  logic   ready;
  epoch_t epoch_seconds;

  modport source(output valid, output epoch_seconds, input ready);
  modport sink(input valid, input epoch_seconds, output ready);
endinterface

// File: hw/rtl/esuc_cal_if.sv
interface esuc_cal_if;
  import esuc_pkg::*;

  logic   valid;
  logic   ready;
  sixty_t second_of_minute;
  sixty_t minute_of_hour;
  hour_t  hour_of_day;
  mday_t  day_of_month;
  month_t month_number;
  year_t  year_number;
  wday_t  weekday;
  logic   clamped;

  modport source(
    output valid, input ready,
    output second_of_minute, output minute_of_hour, output hour_of_day,
    output day_of_month, output month_number, output year_number,
    output weekday, output clamped
  );
  modport sink(
    input valid, output ready,
    input second_of_minute, input minute_of_hour, input hour_of_day,
    input day_of_month, input month_number, input year_number,
    input weekday, input clamped
  );
endinterface

// File: hw/rtl/epoch_seconds_to_utc_calendar_core.sv
// Epoch seconds to UTC calendar fields.
//
// stamp (sink): one beat carries a signed 64-bit count of seconds since
//   1970-01-01 00:00:00 UTC. cal (source): one beat per stamp beat with
//   second, minute, hour, day of month, month, year, weekday (0 = Sunday)
//   and a clamped flag. Negative stamps read as the epoch, stamps past
//   9999-12-31 23:59:59 read as that instant; both raise clamped.
// Path: an accepted stamp beat is registered in stage 1, moves through
//   stages 2 to 8 in order, and the stage 8 result registers drive cal.
// Throughput: one beat per cycle while cal.ready is high, set by an 8-stage
//   pipeline that spreads the reciprocal divides (by 86400, 146097, 3600,
//   100, 60 and the month estimate) so that no stage chains two of them.
// Stall: each stage moves when it is empty or the next one moves, so bubbles
//   are squeezed out and stamp.ready stays high until all 8 stages hold a
//   beat while cal.ready is low. Beats are never dropped or duplicated.
// Reset (rst, synchronous, active high): all stage valids clear; the data
//   registers are not reset. No clearing pass, no configuration.
module epoch_seconds_to_utc_calendar_core (
  input  logic          clk,
  input  logic          rst,
  esuc_stamp_if.sink    stamp,
  esuc_cal_if.source    cal
);
  import esuc_pkg::*;

  // Stage valids and per-stage load enables
  logic [8:1] vld;
  logic [9:1] en;

  always_comb begin
    en[9] = cal.ready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stamp.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= stamp.valid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---- Stage 1: clamp to [0, last second of 9999] -----------------------
  logic        over_in;
  logic [37:0] t_in;
  logic [37:0] t_s1;
  logic        flag_s1;

  assign over_in = !stamp.epoch_seconds[63] && (stamp.epoch_seconds[62:0] >= TIME_LIMIT);

  always_comb begin
    if (stamp.epoch_seconds[63]) begin
      t_in = '0;
    end else if (over_in) begin
      t_in = TIME_LAST;
    end else begin
      t_in = stamp.epoch_seconds[37:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_s1    <= t_in;
      flag_s1 <= stamp.epoch_seconds[63] | over_in;
    end
  end

  // ---- Stage 2: day number by reciprocal multiply ------------------------
  logic [62:0] day_prod;
  logic [21:0] days_s2;
  logic [30:0] hi_s2;
  logic [6:0]  lo_s2;
  logic        flag_s2;

  assign day_prod = 63'(t_s1[37:7]) * 63'(RECIP_675);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      days_s2 <= day_prod[62:41];
      hi_s2   <= t_s1[37:7];
      lo_s2   <= t_s1[6:0];
      flag_s2 <= flag_s1;
    end
  end

  // ---- Stage 3: second of day, March-based day count, weekday ------------
  logic [30:0] day_base;
  logic [30:0] day_rem;
  logic [21:0] d_in;
  logic [16:0] secs_s3;
  logic [21:0] d_s3;
  logic [30:0] n_s3;
  wday_t       wday_s3;
  logic        flag_s3;

  assign day_base = 31'(days_s2) * 31'(DAY_SLICE);
  assign day_rem  = hi_s2 - day_base;
  assign d_in     = days_s2 + MARCH_OFFSET;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      secs_s3 <= {day_rem[9:0], lo_s2};
      d_s3    <= d_in;
      n_s3    <= 31'(d_in + 22'd2) * 31'(YEAR_SCALE);
      wday_s3 <= mod7(23'(days_s2) + EPOCH_WDAY);
      flag_s3 <= flag_s2;
    end
  end

  // ---- Stage 4: year estimate, hour --------------------------------------
  logic [61:0] year_prod;
  logic [26:0] hour_prod;
  year_t       y_s4;
  hour_t       hour_s4;
  logic [16:0] secs_s4;
  logic [21:0] d_s4;
  wday_t       wday_s4;
  logic        flag_s4;

  assign year_prod = 62'(n_s3) * 62'(RECIP_146097);
  assign hour_prod = 27'(secs_s3[16:4]) * 27'(RECIP_3600);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      y_s4    <= year_prod[61:48];
      hour_s4 <= hour_prod[25:21];
      secs_s4 <= secs_s3;
      d_s4    <= d_s3;
      wday_s4 <= wday_s3;
      flag_s4 <= flag_s3;
    end
  end

  // ---- Stage 5: centuries, seconds within the hour -----------------------
  logic [23:0] cent_prod;
  logic [16:0] hour_rem;
  year_t       y_s5;
  logic [6:0]  c_s5;
  logic [11:0] r_s5;
  logic [21:0] d_s5;
  hour_t       hour_s5;
  wday_t       wday_s5;
  logic        flag_s5;

  assign cent_prod = 24'(y_s4[13:2]) * 24'(RECIP_100);
  assign hour_rem  = secs_s4 - 17'(hour_s4) * SECS_PER_HOUR;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      y_s5    <= y_s4;
      c_s5    <= cent_prod[22:16];
      r_s5    <= hour_rem[11:0];
      d_s5    <= d_s4;
      hour_s5 <= hour_s4;
      wday_s5 <= wday_s4;
      flag_s5 <= flag_s4;
    end
  end

  // ---- Stage 6: day of March year with one-year correction, minute -------
  logic [23:0] yday_raw;
  logic [23:0] yday_fix;
  logic        leap;
  logic [20:0] min_prod;
  logic [8:0]  yday_s6;
  year_t       year_s6;
  sixty_t      min_s6;
  logic [11:0] r_s6;
  hour_t       hour_s6;
  wday_t       wday_s6;
  logic        flag_s6;

  // Two's complement in 24 bits; bit 23 set means the estimate overshot.
  assign yday_raw = 24'(d_s5) - 24'(y_s5) * 24'(DAYS_PER_YEAR) - 24'(y_s5[13:2])
                  + 24'(c_s5) - 24'(c_s5[6:2]);
  assign leap     = (y_s5[1:0] == 2'd0)
                  && ((y_s5 != 14'(c_s5) * 14'(YEARS_PER_CENTURY)) || (c_s5[1:0] == 2'd0));
  assign yday_fix = yday_raw + 24'(DAYS_PER_YEAR) + 24'(leap);
  assign min_prod = 21'(r_s5[11:2]) * 21'(RECIP_60);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      yday_s6 <= yday_raw[23] ? yday_fix[8:0] : yday_raw[8:0];
      year_s6 <= yday_raw[23] ? (y_s5 - 14'd1) : y_s5;
      min_s6  <= min_prod[19:14];
      r_s6    <= r_s5;
      hour_s6 <= hour_s5;
      wday_s6 <= wday_s5;
      flag_s6 <= flag_s5;
    end
  end

  // ---- Stage 7: March-based month, second --------------------------------
  logic [21:0] mon_prod;
  logic [11:0] sec_rem;
  month_t      mon_s7;
  logic [8:0]  yday_s7;
  year_t       year_s7;
  sixty_t      sec_s7;
  sixty_t      min_s7;
  hour_t       hour_s7;
  wday_t       wday_s7;
  logic        flag_s7;

  assign mon_prod = 22'(10'(yday_s6) + MONTH_BIAS) * 22'(RECIP_MONTH);
  assign sec_rem  = r_s6 - 12'(min_s6) * SECS_PER_MIN;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      mon_s7  <= mon_prod[21:18];
      yday_s7 <= yday_s6;
      year_s7 <= year_s6;
      sec_s7  <= sec_rem[5:0];
      min_s7  <= min_s6;
      hour_s7 <= hour_s6;
      wday_s7 <= wday_s6;
      flag_s7 <= flag_s6;
    end
  end

  // ---- Stage 8: day of month, shift to January-based month (result reg) --
  logic [8:0] mday_full;
  logic       past_jan;

  assign mday_full = yday_s7 - month_start(mon_s7) + 9'd1;
  assign past_jan  = (yday_s7 >= JAN_DAY_INDEX);

  sixty_t sec_q;
  sixty_t min_q;
  hour_t  hour_q;
  mday_t  mday_q;
  month_t mon_q;
  year_t  year_q;
  wday_t  wday_q;
  logic   flag_q;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      sec_q  <= sec_s7;
      min_q  <= min_s7;
      hour_q <= hour_s7;
      mday_q <= mday_full[4:0];
      mon_q  <= past_jan ? (mon_s7 - MONTH_WRAP) : (mon_s7 + MONTH_SHIFT);
      year_q <= past_jan ? (year_s7 + 14'd1) : year_s7;
      wday_q <= wday_s7;
      flag_q <= flag_s7;
    end
  end

  assign cal.valid            = vld[8];
  assign cal.second_of_minute = sec_q;
  assign cal.minute_of_hour   = min_q;
  assign cal.hour_of_day      = hour_q;
  assign cal.day_of_month     = mday_q;
  assign cal.month_number     = mon_q;
  assign cal.year_number      = year_q;
  assign cal.weekday          = wday_q;
  assign cal.clamped          = flag_q;

  // ---- Checks -------------------------------------------------------------
  // Occupancy tracks beats in minus beats out.
  a_occupancy_in : assert property (@(posedge clk) disable iff (rst)
    (stamp.valid && stamp.ready && !(cal.valid && cal.ready))
    |=> ($countones(vld) == $past($countones(vld)) + 1))
    else $error("pipeline occupancy did not grow on an input beat");

  a_occupancy_out : assert property (@(posedge clk) disable iff (rst)
    (!(stamp.valid && stamp.ready) && cal.valid && cal.ready)
    |=> ($countones(vld) + 1 == $past($countones(vld))))
    else $error("pipeline occupancy did not shrink on an output beat");

  // Input is only refused when every stage is full and the sink stalls.
  a_ready_full : assert property (@(posedge clk) disable iff (rst)
    !stamp.ready |-> ((&vld) && !cal.ready))
    else $error("input refused with room in the pipeline");

  // Month, day of month, weekday and year of a delivered beat are in range.
  a_fields : assert property (@(posedge clk) disable iff (rst)
    cal.valid |-> (cal.month_number >= 4'd1 && cal.month_number <= 4'd12
                   && cal.day_of_month >= 5'd1 && cal.weekday <= 3'd6
                   && cal.year_number >= 14'd1970 && cal.year_number <= 14'd9999))
    else $error("calendar field out of range");

endmodule
